### design/causal_depthwise_conv1d_silu_top_defines.svh
// Assertion macros for the causal depthwise conv1d SiLU block.
// No dependencies; each macro expands to nothing when SYNTHESIS is defined.
`ifndef CAUSAL_DEPTHWISE_CONV1D_SILU_TOP_DEFINES_SVH
`define CAUSAL_DEPTHWISE_CONV1D_SILU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DWC_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("dwc assertion failed");
`define DWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dwc assertion failed");
`else
`define DWC_ASSERT_NEVER(lbl, clk, rstn, cond)
`define DWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/dwc_pkg.sv
// Shared types and constants of the causal depthwise conv1d SiLU block.
// No dependencies.
package dwc_pkg;
	localparam int CHANNELS_DEF  = 1024;
	localparam int MAX_TAPS_DEF  = 4;
	localparam int SIG_SIZE_DEF  = 256;
	localparam int Q_DEPTH       = 4;
	localparam int OUT_DEPTH     = 8;
	localparam int OUT_CNT_W     = 4;
	localparam int ADDR_W        = 3;
	localparam int CH_W          = 10;
	localparam logic REG_TAPS    = 1'b0;
	localparam logic [2:0] TAPS_RESET = 3'd4;

	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_WEIGHT = 2'd1;
	localparam logic [1:0] ACT_BIAS   = 2'd2;

	typedef enum logic [1:0] {OP_PUSH, OP_WEIGHT, OP_BIAS} op_t;

	typedef struct packed {
		op_t               op;
		logic [CH_W-1:0]   chan;
		logic [1:0]        tap;
		logic signed [15:0] value;
		logic              first;
	} q_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    chan;
		logic signed [15:0] activation;
		logic               saturated;
	} res_item_t;

	typedef struct packed {
		logic clearing;
		logic q_pop;
	} back_stat_t;
endpackage

### design/dwc_fifo.sv
// Small synchronous queue of fixed-width words.
// No dependencies beyond the standard flip-flop style of the project.
module dwc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic [$clog2(DEPTH):0] count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign dout  = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= din;
	end
endmodule

### design/dwc_front.sv
// Front end: accepts requests, drops those that do nothing, and queues the rest.
// Depends on dwc_pkg and dwc_fifo.
module dwc_front import dwc_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [1:0]         action,
	input  logic [CH_W-1:0]    channel,
	input  logic [1:0]         tap,
	input  logic signed [15:0] value,
	input  logic               first_in_sequence,
	output logic               full,
	input  logic               blocked,
	input  logic               q_pop,
	output q_item_t            q_item,
	output logic               q_empty
);
	q_item_t item;
	logic    keep, q_full;
	logic [$clog2(Q_DEPTH):0] q_count;

	always_comb begin
		item.chan  = channel;
		item.tap   = tap;
		item.value = value;
		item.first = first_in_sequence;
		item.op    = OP_PUSH;
		keep       = ({4'b0, channel} < 14'(CHANNELS));
		case (action)
			ACT_PUSH:   item.op = OP_PUSH;
			ACT_WEIGHT: begin
				item.op = OP_WEIGHT;
				if ({2'b0, tap} >= 4'(MAX_TAPS)) keep = 1'b0;
			end
			ACT_BIAS:   item.op = OP_BIAS;
			default:    keep = 1'b0;
		endcase
	end

	assign full = q_full || blocked;

	dwc_fifo #(.WIDTH($bits(q_item_t)), .DEPTH(Q_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push && !full && keep),
		.din   (item),
		.full  (q_full),
		.rd    (q_pop),
		.dout  (q_item),
		.empty (q_empty),
		.count (q_count)
	);

	logic unused_cnt;
	assign unused_cnt = ^q_count;
endmodule

### design/dwc_back.sv
// Back end: channel memories, tap products, bias sum, sigmoid lookup and SiLU rounding.
// Depends on dwc_pkg.
module dwc_back import dwc_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	parameter int SIG_SIZE = SIG_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  q_item_t               q_item,
	input  logic [$clog2(MAX_TAPS+1)-1:0] kt,
	input  logic [OUT_CNT_W-1:0]  out_count,
	output logic                  res_valid,
	output res_item_t             res_item,
	output back_stat_t            stat
);
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HD    = MAX_TAPS - 1;
	localparam int HD_W  = (HD > 1) ? $clog2(HD) : 1;
	localparam int KT_W  = $clog2(MAX_TAPS+1);
	localparam int TAP_W = $clog2(MAX_TAPS);
	localparam int ACC_W = 33 + $clog2(MAX_TAPS+1);
	localparam int IDX_W = $clog2(SIG_SIZE);
	localparam int IW    = ACC_W + 13;
	localparam int MW    = ACC_W + 17;

	// Sigmoid table in unsigned Q1.16, evaluated at elaboration.
	logic [16:0] sig_rom [SIG_SIZE];
	for (genvar gi = 0; gi < SIG_SIZE; gi++) begin : g_sig
		localparam int D = 2*gi + 1 - SIG_SIZE;
		localparam logic [63:0] AD = 64'((D < 0) ? -D : D);
		localparam logic [63:0] Z  = ((AD << 33) / SIG_SIZE) >> 8;
		localparam logic [63:0] T0 = 64'd1 << 30;
		localparam logic [63:0] T1 = ((T0 * Z) >> 30) / 64'd1;
		localparam logic [63:0] T2 = ((T1 * Z) >> 30) / 64'd2;
		localparam logic [63:0] T3 = ((T2 * Z) >> 30) / 64'd3;
		localparam logic [63:0] T4 = ((T3 * Z) >> 30) / 64'd4;
		localparam logic [63:0] T5 = ((T4 * Z) >> 30) / 64'd5;
		localparam logic [63:0] T6 = ((T5 * Z) >> 30) / 64'd6;
		localparam logic [63:0] E0 = T0 - T1 + T2 - T3 + T4 - T5 + T6;
		localparam logic [63:0] E1 = (E0 * E0 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E2 = (E1 * E1 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E3 = (E2 * E2 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E4 = (E3 * E3 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E5 = (E4 * E4 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E6 = (E5 * E5 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E7 = (E6 * E6 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] E8 = (E7 * E7 + (64'd1 << 29)) >> 30;
		localparam logic [63:0] DEN = (64'd1 << 30) + E8;
		localparam logic [63:0] SV = (D > 0) ? (((64'd1 << 46) + DEN / 64'd2) / DEN)
		                                     : (((E8 << 16) + DEN / 64'd2) / DEN);
		assign sig_rom[gi] = SV[16:0];
	end

	// Memories
	logic [HD*16-1:0]   hist_mem [CHANNELS];
	logic signed [15:0] bias_mem [CHANNELS];

	logic              clearing_q;
	logic [CH_AW-1:0]  clr_q;
	logic [3:0]        inflight_q;
	logic              pop, pop_push;
	logic [CH_AW-1:0]  q_addr;
	logic [TAP_W-1:0]  q_tap;

	assign q_addr = CH_AW'({3'b0, q_item.chan});
	assign q_tap  = TAP_W'({1'b0, q_item.tap});
	assign pop    = !q_empty && !clearing_q &&
	                ({1'b0, out_count} + {1'b0, inflight_q} < 5'(OUT_DEPTH));
	// Only pushes produce a result, so only they hold a slot of the output queue.
	assign pop_push = pop && q_item.op == OP_PUSH;

	// Stage 1 registers: request plus registered memory reads.
	logic               v_s1, first_s1;
	op_t                op_s1;
	logic [CH_W-1:0]    ch_s1;
	logic signed [15:0] val_s1, bias_rd_s1;
	logic [HD*16-1:0]   hist_rd_s1;
	logic signed [15:0] w_rd_s1 [MAX_TAPS];

	for (genvar gk = 0; gk < MAX_TAPS; gk++) begin : g_wmem
		logic signed [15:0] wmem [CHANNELS];
		always_ff @(posedge clk) begin
			if (pop && q_item.op == OP_WEIGHT && q_tap == TAP_W'(gk))
				wmem[q_addr] <= q_item.value;
			w_rd_s1[gk] <= wmem[q_addr];
		end
	end

	logic               pv_s1, pv_s2;
	logic [CH_W-1:0]    ch_s2;
	logic [HD*16-1:0]   hist_new, hist_new_s2;
	logic signed [15:0] base_h [HD];
	logic signed [15:0] xs [MAX_TAPS];
	logic [CH_AW-1:0]   hist_wa;
	logic               hist_we;
	logic [HD*16-1:0]   hist_wd;

	assign pv_s1   = v_s1 && op_s1 == OP_PUSH;
	assign hist_we = clearing_q || pv_s1;
	assign hist_wa = clearing_q ? clr_q : CH_AW'({3'b0, ch_s1});
	assign hist_wd = clearing_q ? '0 : hist_new;

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_wa] <= hist_wd;
		hist_rd_s1 <= hist_mem[q_addr];
		if (clearing_q) bias_mem[clr_q] <= '0;
		else if (pop && q_item.op == OP_BIAS) bias_mem[q_addr] <= q_item.value;
		bias_rd_s1 <= bias_mem[q_addr];
		op_s1    <= q_item.op;
		ch_s1    <= q_item.chan;
		val_s1   <= q_item.value;
		first_s1 <= q_item.first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			inflight_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == CH_AW'(CHANNELS - 1)) clearing_q <= 1'b0;
			end
			v_s1 <= pop;
			if (pop_push && !res_valid) inflight_q <= inflight_q + 1'b1;
			else if (res_valid && !pop_push) inflight_q <= inflight_q - 1'b1;
		end
	end

	// History row of the previous push forwards when the channel repeats.
	always_comb begin
		logic [HD*16-1:0] base_row;
		logic [KT_W-1:0]  age;
		logic [HD_W-1:0]  hidx;
		base_row = (pv_s2 && ch_s2 == ch_s1) ? hist_new_s2 : hist_rd_s1;
		if (first_s1) base_row = '0;
		for (int a = 0; a < HD; a++) base_h[a] = base_row[a*16 +: 16];
		hist_new[15:0] = val_s1;
		for (int a = 1; a < HD; a++) hist_new[a*16 +: 16] = base_h[a-1];
		for (int k = 0; k < MAX_TAPS; k++) begin
			age  = kt - KT_W'(1) - KT_W'(k);
			hidx = HD_W'(age - KT_W'(1));
			if (KT_W'(k) >= kt) xs[k] = '0;
			else if (age == '0) xs[k] = val_s1;
			else xs[k] = base_h[hidx];
		end
	end

	// Stage 2: products.
	logic signed [31:0] prod_s2 [MAX_TAPS];
	logic signed [15:0] bias_s2;
	logic               v_s2;
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_TAPS; k++) prod_s2[k] <= w_rd_s1[k] * xs[k];
		bias_s2     <= bias_rd_s1;
		hist_new_s2 <= hist_new;
		ch_s2       <= ch_s1;
	end

	// Stage 3: accumulate.
	logic signed [ACC_W-1:0] acc_s3, acc_sum;
	logic [CH_W-1:0]         ch_s3, ch_s4, ch_s5;
	logic                    v_s3, v_s4, v_s5;
	always_comb begin
		acc_sum = ACC_W'(bias_s2) <<< 12;
		for (int k = 0; k < MAX_TAPS; k++) acc_sum = acc_sum + ACC_W'(prod_s2[k]);
	end
	always_ff @(posedge clk) begin
		acc_s3 <= acc_sum;
		ch_s3  <= ch_s2;
	end

	// Stage 4: sigmoid lookup and magnitude.
	logic signed [ACC_W-1:0] shifted;
	logic [IW-1:0]           idx_w;
	logic [IDX_W-1:0]        idx;
	logic [16:0]             entry_s4;
	logic [ACC_W-1:0]        abs_s4;
	logic                    neg_s4, neg_s5;
	always_comb begin
		shifted = acc_s3 + (ACC_W'(1) <<< 27);
		idx_w   = (IW'(unsigned'(shifted)) * IW'(SIG_SIZE)) >> 28;
		if (shifted[ACC_W-1]) idx = '0;
		else if (idx_w > IW'(SIG_SIZE - 1)) idx = IDX_W'(SIG_SIZE - 1);
		else idx = idx_w[IDX_W-1:0];
	end
	always_ff @(posedge clk) begin
		entry_s4 <= sig_rom[idx];
		abs_s4   <= acc_s3[ACC_W-1] ? unsigned'(-acc_s3) : unsigned'(acc_s3);
		neg_s4   <= acc_s3[ACC_W-1];
		ch_s4    <= ch_s3;
	end

	// Stage 5: SiLU product, then rounding and clipping.
	logic [MW-1:0] mag_s5;
	always_ff @(posedge clk) begin
		mag_s5 <= MW'(abs_s4) * MW'(entry_s4);
		neg_s5 <= neg_s4;
		ch_s5  <= ch_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			pv_s2 <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			v_s2  <= pv_s1;
			pv_s2 <= pv_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
		end
	end

	logic [MW:0] rnd;
	always_comb begin
		rnd = ({1'b0, mag_s5} + (MW+1)'(1 << 27)) >> 28;
		res_item.chan = ch_s5;
		res_item.saturated = 1'b0;
		if (!neg_s5) begin
			if (rnd > (MW+1)'(32767)) begin
				res_item.activation = 16'sh7fff;
				res_item.saturated  = 1'b1;
			end else res_item.activation = signed'(rnd[15:0]);
		end else begin
			if (rnd > (MW+1)'(32768)) begin
				res_item.activation = -16'sh8000;
				res_item.saturated  = 1'b1;
			end else res_item.activation = signed'(16'(-rnd[16:0]));
		end
	end

	// Writes leave the pipeline after stage 1; only pushes reach stage 5.
	assign res_valid     = v_s5;
	assign stat.clearing = clearing_q;
	assign stat.q_pop    = pop;
endmodule

### design/causal_depthwise_conv1d_silu_top.sv
// Causal depthwise conv1d with SiLU: one request per cycle while full is low.
// A push passes through memory read, product, sum, table lookup, SiLU product and round
// into the output queue; one request per cycle while the output queue has room.
// After reset the history and bias memories are cleared one channel per cycle, with full
// held high; weights are undefined until written.
// Depends on dwc_pkg, dwc_front, dwc_back, dwc_fifo and the defines header.
`include "causal_depthwise_conv1d_silu_top_defines.svh"
module causal_depthwise_conv1d_silu_top import dwc_pkg::*; #(
	parameter int CHANNELS           = CHANNELS_DEF,
	parameter int MAX_TAPS           = MAX_TAPS_DEF,
	parameter int SIGMOID_TABLE_SIZE = SIG_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [CH_W-1:0]    channel,
	input  logic [1:0]         tap,
	input  logic signed [15:0] value,
	input  logic               first_in_sequence,
	output logic               empty,
	input  logic               pop,
	output logic [CH_W-1:0]    out_channel,
	output logic signed [15:0] activation,
	output logic               saturated
);
	localparam int KT_W = $clog2(MAX_TAPS+1);

	logic [2:0]      taps_q;
	logic [KT_W-1:0] kt;
	q_item_t         q_item;
	logic            q_empty;
	back_stat_t      stat;
	logic            res_valid, out_full;
	res_item_t       res_item, out_item;
	logic [OUT_CNT_W-1:0] out_count;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TAPS) ? {29'b0, taps_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) taps_q <= TAPS_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_TAPS) taps_q <= pwdata[2:0];
	end

	always_comb begin
		if (taps_q == 3'd0) kt = KT_W'(1);
		else if ({1'b0, taps_q} > 4'(MAX_TAPS)) kt = KT_W'(MAX_TAPS);
		else kt = KT_W'(taps_q);
	end

	dwc_front #(.CHANNELS(CHANNELS), .MAX_TAPS(MAX_TAPS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .action(action), .channel(channel),
		.tap(tap), .value(value), .first_in_sequence(first_in_sequence), .full(full),
		.blocked(stat.clearing), .q_pop(stat.q_pop), .q_item(q_item), .q_empty(q_empty)
	);

	dwc_back #(.CHANNELS(CHANNELS), .MAX_TAPS(MAX_TAPS), .SIG_SIZE(SIGMOID_TABLE_SIZE)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(q_item), .kt(kt),
		.out_count(out_count), .res_valid(res_valid), .res_item(res_item), .stat(stat)
	);

	dwc_fifo #(.WIDTH($bits(res_item_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .wr(res_valid), .din(res_item), .full(out_full),
		.rd(pop), .dout(out_item), .empty(empty), .count(out_count)
	);

	assign out_channel = out_item.chan;
	assign activation  = out_item.activation;
	assign saturated   = out_item.saturated;

	`DWC_ASSERT_NEVER(a_out_no_overflow, clk, arst_n, res_valid && out_full)
	`DWC_ASSERT_NEVER(a_no_accept_clearing, clk, arst_n, stat.clearing && !full)
	`DWC_ASSERT_IMPL(a_pop_not_clearing, clk, arst_n, stat.q_pop, !stat.clearing && !q_empty)
endmodule
